[hdl/c_sl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_sl_pkg
// Shared types, token kind codes and character helpers of the C subset lexer.
// ----------------------------------------------------------------------------
package c_sl_pkg;

    typedef enum logic [4:0] {
        M_IDLE  = 5'b00001,
        M_IDENT = 5'b00010,
        M_NUM   = 5'b00100,
        M_EQ    = 5'b01000,
        M_BANG  = 5'b10000
    } t_mode;

    localparam logic [4:0] K_IDENT  = 5'd0;
    localparam logic [4:0] K_RETURN = 5'd1;
    localparam logic [4:0] K_NUMBER = 5'd2;
    localparam logic [4:0] K_EQ     = 5'd3;
    localparam logic [4:0] K_NEQ    = 5'd4;
    localparam logic [4:0] K_PLUS   = 5'd5;
    localparam logic [4:0] K_MINUS  = 5'd6;
    localparam logic [4:0] K_STAR   = 5'd7;
    localparam logic [4:0] K_SLASH  = 5'd8;
    localparam logic [4:0] K_PCT    = 5'd9;
    localparam logic [4:0] K_LPAREN = 5'd10;
    localparam logic [4:0] K_RPAREN = 5'd11;
    localparam logic [4:0] K_ASSIGN = 5'd12;
    localparam logic [4:0] K_SEMI   = 5'd13;
    localparam logic [4:0] K_COMMA  = 5'd14;
    localparam logic [4:0] K_END    = 5'd15;
    localparam logic [4:0] K_ERROR  = 5'd16;

    localparam logic [2:0]  KW_LEN  = 3'd6;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start_res;
        logic [15:0] length;
        logic        end_of_run;
    } t_tok_hdr;

    typedef struct packed {
        logic fire;
        logic is_end;
        logic halted;
    } t_lex_stat;

    function automatic logic [7:0] f_kw_char(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h72;
            3'd1:    r = 8'h65;
            3'd2:    r = 8'h74;
            3'd3:    r = 8'h75;
            3'd4:    r = 8'h72;
            3'd5:    r = 8'h6E;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // single-character operators and punctuation; K_ERROR when none
    function automatic logic [4:0] f_single_kind(input logic [7:0] c);
        logic [4:0] r;
        case (c)
            8'h2B:   r = K_PLUS;
            8'h2D:   r = K_MINUS;
            8'h2A:   r = K_STAR;
            8'h2F:   r = K_SLASH;
            8'h25:   r = K_PCT;
            8'h28:   r = K_LPAREN;
            8'h29:   r = K_RPAREN;
            8'h3D:   r = K_ASSIGN;
            8'h3B:   r = K_SEMI;
            8'h2C:   r = K_COMMA;
            default: r = K_ERROR;
        endcase
        return r;
    endfunction

endpackage

[hdl/c_sl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_sl_in_if / c_sl_out_if
// Valid/ready channels carrying source bytes in and tokens out.
// ----------------------------------------------------------------------------
interface c_sl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface c_sl_out_if #(
    parameter int VALUE_WIDTH = 31
);
    logic                   valid;
    logic                   ready;
    logic [4:0]             kind;
    logic [15:0]            start_res;
    logic [15:0]            length;
    logic [VALUE_WIDTH-1:0] value;
    logic                   end_of_run;

    modport source (output valid, output kind, output start_res, output length,
                    output value, output end_of_run, input ready);
    modport sink   (input valid, input kind, input start_res, input length,
                    input value, input end_of_run, output ready);
endinterface

[hdl/c_sl_lex.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_sl_lex
// Input register, lexer state and the per-byte tokenizing logic; emits zero,
// one or two tokens per item into the result queue.
// ----------------------------------------------------------------------------
module c_sl_lex import c_sl_pkg::*; #(
    parameter int TEXT_LEN    = 65536,
    parameter int VALUE_WIDTH = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_ch,
    input  logic                        i_is_end,
    input  logic                        i_room,
    output logic [1:0]                  o_push_n,
    output t_tok_hdr [1:0]              o_hdr,
    output logic [1:0][VALUE_WIDTH-1:0] o_val,
    output t_lex_stat                   o_stat
);

    localparam int PW = $clog2(TEXT_LEN + 1);
    localparam int WW = VALUE_WIDTH + 4;
    localparam logic [PW-1:0]          POS_LIMIT = PW'(TEXT_LEN);
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX   = {VALUE_WIDTH{1'b1}};

    logic                   r_in_valid;
    logic [7:0]             r_ch;
    logic                   r_is_end;
    t_mode                  r_mode,      n_mode;
    logic [2:0]             r_kw_prog,   n_kw_prog;
    logic                   r_kw_alive,  n_kw_alive;
    logic [PW-1:0]          r_tok_start, n_tok_start;
    logic [15:0]            r_tok_len,   n_tok_len;
    logic [VALUE_WIDTH-1:0] r_num,       n_num;
    logic [PW-1:0]          r_pos,       n_pos;
    logic                   r_halted,    n_halted;

    logic                   w_fire;
    logic                   f_valid;
    t_tok_hdr               f_hdr;
    logic [VALUE_WIDTH-1:0] f_val;
    logic                   f_halt;
    logic                   c_alpha, c_digit, c_space;
    logic [4:0]             c_single;
    logic [3:0]             c_dval;
    logic [WW-1:0]          w_num_wide;
    logic [VALUE_WIDTH-1:0] w_num_next;

    function automatic logic [15:0] f_clamp(input logic [PW-1:0] v);
        logic [15:0] r;
        if (v > PW'(LEN_MAX)) begin
            r = LEN_MAX;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    function automatic t_tok_hdr f_mk(input logic [4:0] kind, input logic [PW-1:0] start,
                                      input logic [15:0] len);
        t_tok_hdr h;
        h.kind       = kind;
        h.start_res  = f_clamp(start);
        h.length     = len;
        h.end_of_run = 1'b0;
        return h;
    endfunction

    assign w_fire  = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;
    assign o_stat  = '{fire: w_fire, is_end: r_is_end, halted: r_halted};

    // hold the item until the queue has room for two tokens
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ch     <= i_ch;
            r_is_end <= i_is_end;
        end
    end

    assign c_alpha  = (r_ch >= 8'h61 && r_ch <= 8'h7A) || (r_ch >= 8'h41 && r_ch <= 8'h5A)
                      || r_ch == 8'h5F;
    assign c_digit  = r_ch >= 8'h30 && r_ch <= 8'h39;
    assign c_space  = r_ch == 8'h20 || (r_ch >= 8'h09 && r_ch <= 8'h0D);
    assign c_single = f_single_kind(r_ch);
    assign c_dval   = 4'(r_ch - 8'h30);

    assign w_num_wide = (WW'(r_num) << 3) + (WW'(r_num) << 1) + WW'(c_dval);
    assign w_num_next = (w_num_wide > WW'(VAL_MAX)) ? VAL_MAX : w_num_wide[VALUE_WIDTH-1:0];

    // pending token as it would be emitted now
    always_comb begin
        f_valid = 1'b1;
        f_halt  = 1'b0;
        f_val   = '0;
        f_hdr   = f_mk(K_ERROR, r_tok_start, 16'd1);
        unique case (r_mode)
            M_IDLE: begin
                f_valid = 1'b0;
            end
            M_IDENT: begin
                f_hdr = f_mk((r_kw_alive && r_kw_prog == KW_LEN) ? K_RETURN : K_IDENT,
                             r_tok_start, r_tok_len);
            end
            M_NUM: begin
                f_hdr = f_mk(K_NUMBER, r_tok_start, r_tok_len);
                f_val = r_num;
            end
            M_EQ: begin
                f_hdr = f_mk(K_ASSIGN, r_tok_start, 16'd1);
            end
            M_BANG: begin
                f_halt = 1'b1;
            end
            default: begin
                f_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic [1:0] v_n;
        v_n         = 2'd0;
        o_hdr       = '0;
        o_val       = '0;
        n_mode      = r_mode;
        n_kw_prog   = r_kw_prog;
        n_kw_alive  = r_kw_alive;
        n_tok_start = r_tok_start;
        n_tok_len   = r_tok_len;
        n_num       = r_num;
        n_pos       = r_pos;
        n_halted    = r_halted;
        if (w_fire) begin
            if (r_is_end) begin
                if (!r_halted && f_valid) begin
                    o_hdr[v_n[0]] = f_hdr;
                    o_val[v_n[0]] = f_val;
                    v_n           = v_n + 2'd1;
                end
                o_hdr[v_n[0]] = f_mk(K_END, r_pos, 16'd0);
                v_n           = v_n + 2'd1;
                n_mode        = M_IDLE;
                n_kw_prog     = '0;
                n_kw_alive    = 1'b0;
                n_tok_start   = '0;
                n_tok_len     = '0;
                n_num         = '0;
                n_pos         = '0;
                n_halted      = 1'b0;
            end else if (r_halted) begin
                v_n = 2'd0;
            end else if (r_pos == POS_LIMIT) begin
                if (f_valid) begin
                    o_hdr[v_n[0]] = f_hdr;
                    o_val[v_n[0]] = f_val;
                    v_n           = v_n + 2'd1;
                end
                if (r_mode != M_BANG) begin
                    o_hdr[v_n[0]] = f_mk(K_ERROR, r_pos, 16'd0);
                    v_n           = v_n + 2'd1;
                end
                n_halted = 1'b1;
                n_mode   = M_IDLE;
            end else begin
                n_pos = r_pos + PW'(1);
                if (r_mode == M_IDENT && (c_alpha || c_digit)) begin
                    if (r_kw_alive) begin
                        if (r_kw_prog < KW_LEN && f_kw_char(r_kw_prog) == r_ch) begin
                            n_kw_prog = r_kw_prog + 3'd1;
                        end else begin
                            n_kw_alive = 1'b0;
                        end
                    end
                    if (r_tok_len != LEN_MAX) n_tok_len = r_tok_len + 16'd1;
                end else if (r_mode == M_NUM && c_digit) begin
                    n_num = w_num_next;
                    if (r_tok_len != LEN_MAX) n_tok_len = r_tok_len + 16'd1;
                end else if (r_mode == M_EQ && r_ch == 8'h3D) begin
                    n_mode   = M_IDLE;
                    o_hdr[0] = f_mk(K_EQ, r_tok_start, 16'd2);
                    v_n      = 2'd1;
                end else if (r_mode == M_BANG) begin
                    n_mode = M_IDLE;
                    if (r_ch == 8'h3D) begin
                        o_hdr[0] = f_mk(K_NEQ, r_tok_start, 16'd2);
                    end else begin
                        n_halted = 1'b1;
                        o_hdr[0] = f_mk(K_ERROR, r_tok_start, 16'd1);
                    end
                    v_n = 2'd1;
                end else begin
                    if (f_valid) begin
                        o_hdr[0] = f_hdr;
                        o_val[0] = f_val;
                        v_n      = 2'd1;
                        if (f_halt) n_halted = 1'b1;
                    end
                    n_mode = M_IDLE;
                    if (!c_space) begin
                        n_tok_start = r_pos;
                        n_tok_len   = 16'd1;
                        n_num       = '0;
                        if (c_alpha) begin
                            n_mode     = M_IDENT;
                            n_kw_alive = (r_ch == f_kw_char(3'd0));
                            n_kw_prog  = (r_ch == f_kw_char(3'd0)) ? 3'd1 : 3'd0;
                        end else if (r_ch == 8'h3D) begin
                            n_mode = M_EQ;
                        end else if (r_ch == 8'h21) begin
                            n_mode = M_BANG;
                        end else if (c_single != K_ERROR) begin
                            o_hdr[v_n[0]] = f_mk(c_single, r_pos, 16'd1);
                            v_n           = v_n + 2'd1;
                        end else if (c_digit) begin
                            n_mode = M_NUM;
                            n_num  = VALUE_WIDTH'(c_dval);
                        end else begin
                            n_halted      = 1'b1;
                            o_hdr[v_n[0]] = f_mk(K_ERROR, r_pos, 16'd1);
                            v_n           = v_n + 2'd1;
                        end
                    end
                end
            end
        end
        // mark the last token of this item
        if (v_n == 2'd2) begin
            o_hdr[1].end_of_run = 1'b1;
        end else if (v_n == 2'd1) begin
            o_hdr[0].end_of_run = 1'b1;
        end
        o_push_n = v_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_kw_prog   <= '0;
            r_kw_alive  <= 1'b0;
            r_tok_start <= '0;
            r_tok_len   <= '0;
            r_num       <= '0;
            r_pos       <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_kw_prog   <= n_kw_prog;
            r_kw_alive  <= n_kw_alive;
            r_tok_start <= n_tok_start;
            r_tok_len   <= n_tok_len;
            r_num       <= n_num;
            r_pos       <= n_pos;
            r_halted    <= n_halted;
        end
    end

endmodule

[hdl/c_sl_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_sl_outq
// Four-entry token queue; takes up to two tokens per cycle, drives one out.
// ----------------------------------------------------------------------------
module c_sl_outq import c_sl_pkg::*; #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_push_n,
    input  t_tok_hdr [1:0]              i_hdr,
    input  logic [1:0][VALUE_WIDTH-1:0] i_val,
    output logic                        o_room,
    output logic                        o_valid,
    input  logic                        i_ready,
    output t_tok_hdr                    o_hdr,
    output logic [VALUE_WIDTH-1:0]      o_val
);

    t_tok_hdr               r_hdr [4];
    logic [VALUE_WIDTH-1:0] r_val [4];
    logic [1:0]             r_wr_ptr, n_wr_ptr;
    logic [1:0]             r_rd_ptr, n_rd_ptr;
    logic [2:0]             r_count,  n_count;
    logic                   w_pop;

    assign o_room  = r_count <= 3'd2;
    assign o_valid = r_count != 3'd0;
    assign o_hdr   = r_hdr[r_rd_ptr];
    assign o_val   = r_val[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    assign n_wr_ptr = r_wr_ptr + i_push_n;
    assign n_rd_ptr = r_rd_ptr + {1'b0, w_pop};
    assign n_count  = r_count + {1'b0, i_push_n} - {2'b00, w_pop};

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_hdr[r_wr_ptr] <= i_hdr[0];
            r_val[r_wr_ptr] <= i_val[0];
        end
        if (i_push_n == 2'd2) begin
            r_hdr[r_wr_ptr + 2'd1] <= i_hdr[1];
            r_val[r_wr_ptr + 2'd1] <= i_val[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[hdl/c_subset_lexer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_lexer_core
// Streaming lexer for a small C expression language: one source byte per
// item in, identifier/keyword/number/operator/end/error tokens out.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         handshake
//  i_src    in   ch[7:0], is_end                                 valid/ready
//  o_res    out  kind[4:0], start_res, length, value, end_of_run valid/ready
//
//  One item per cycle while the queue has room for two tokens; an item
//  passes the input register, then the token queue. Items with two tokens
//  can fill the four-entry token queue, which then backs up; input ready drops.
//  Synchronous active-low reset clears lexer state and the queue; no
//  clearing pass. Input is held in its register while the queue is short
//  of room for two tokens.
// ----------------------------------------------------------------------------
module c_subset_lexer_core import c_sl_pkg::*; #(
    parameter int TEXT_LEN    = 65536,
    parameter int VALUE_WIDTH = 31
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    c_sl_in_if.sink  i_src,
    c_sl_out_if.source o_res
);

    logic                        w_room;
    logic [1:0]                  w_push_n;
    t_tok_hdr [1:0]              w_hdr;
    logic [1:0][VALUE_WIDTH-1:0] w_val;
    t_lex_stat                   w_stat;
    t_tok_hdr                    w_out_hdr;
    logic [VALUE_WIDTH-1:0]      w_out_val;
    logic                        w_in_ready;
    logic                        w_out_valid;

    c_sl_lex #(
        .TEXT_LEN    (TEXT_LEN),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_lex (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_src.valid),
        .o_ready  (w_in_ready),
        .i_ch     (i_src.ch),
        .i_is_end (i_src.is_end),
        .i_room   (w_room),
        .o_push_n (w_push_n),
        .o_hdr    (w_hdr),
        .o_val    (w_val),
        .o_stat   (w_stat)
    );

    c_sl_outq #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_hdr    (w_hdr),
        .i_val    (w_val),
        .o_room   (w_room),
        .o_valid  (w_out_valid),
        .i_ready  (o_res.ready),
        .o_hdr    (w_out_hdr),
        .o_val    (w_out_val)
    );

    assign i_src.ready      = w_in_ready;
    assign o_res.valid      = w_out_valid;
    assign o_res.kind       = w_out_hdr.kind;
    assign o_res.start_res  = w_out_hdr.start_res;
    assign o_res.length     = w_out_hdr.length;
    assign o_res.value      = w_out_val;
    assign o_res.end_of_run = w_out_hdr.end_of_run;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_room |-> w_push_n == 2'd0)
        else $error("tokens pushed into a full queue");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.fire && w_stat.is_end |-> w_push_n != 2'd0 && w_push_n != 2'd3)
        else $error("end item produced no end token");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.fire && w_stat.halted && !w_stat.is_end |-> w_push_n == 2'd0)
        else $error("halted lexer emitted a token");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.fire && w_stat.is_end |=> !w_stat.halted)
        else $error("halt not cleared by end item");

endmodule

[dv/tb_c_subset_lexer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_subset_lexer_core
// Self-checking bench for the streaming C subset lexer. Source bytes go in
// over the input channel and every accepted byte is run through a lexer
// model kept in the bench. Each output token is checked against the oldest
// expected token. The run covers the token kinds, error and halt handling,
// a long output stall, and random texts.
// ----------------------------------------------------------------------------
module tb_c_subset_lexer_core;
    import c_sl_pkg::*;

    localparam int TEXT_LEN = 65536;
    localparam int VAL_W    = 31;
    localparam longint unsigned VAL_MAX = (64'd1 << VAL_W) - 1;

    typedef struct packed {
        logic [4:0]       kind;
        logic [15:0]      start_res;
        logic [15:0]      length;
        logic [VAL_W-1:0] value;
        logic             end_of_run;
    } t_tok;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    c_sl_in_if                         src ();
    c_sl_out_if #(.VALUE_WIDTH(VAL_W)) res ();

    c_subset_lexer_core #(
        .TEXT_LEN    (TEXT_LEN),
        .VALUE_WIDTH (VAL_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src),
        .o_res   (res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    string kw_word    = "return";
    string op_chars   = "+-*/%()=;,";
    string blank_chrs = "\t\n\v\f\r ";

    t_tok tok_expect_q [$];
    t_tok step_buf [0:1];
    int   step_n;

    t_mode           lx_mode;
    int unsigned     kw_prog;
    bit              kw_alive;
    int unsigned     tok_start;
    int unsigned     tok_len;
    longint unsigned num_val;
    int unsigned     lx_pos;
    bit              lx_halted;

    int err_cnt        = 0;
    int lexed_cnt      = 0;
    int texts_done     = 0;
    int tokens_checked = 0;
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int rx_hold        = 0;

    function automatic logic [15:0] sat16(input int unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        k = K_ERROR;
        for (int i = 0; i < 10; i++) begin
            if (op_chars[i] == c) k = 5'(K_PLUS + i);
        end
        return k;
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_ident_char();
        if ($urandom_range(4) == 0) return 8'("0" + $urandom_range(9));
        return rand_letter();
    endfunction

    function automatic logic [7:0] rand_blank();
        return blank_chrs[$urandom_range(5)];
    endfunction

    task automatic lex_reset();
        lx_mode   = M_IDLE;
        kw_prog   = 0;
        kw_alive  = 1'b0;
        tok_start = 0;
        tok_len   = 0;
        num_val   = 0;
        lx_pos    = 0;
        lx_halted = 1'b0;
    endtask

    task automatic emit_tok(input logic [4:0] k, input int unsigned st, input int unsigned ln,
                            input longint unsigned v);
        t_tok t;
        t.kind       = k;
        t.start_res  = sat16(st);
        t.length     = sat16(ln);
        t.value      = v[VAL_W-1:0];
        t.end_of_run = 1'b0;
        step_buf[step_n] = t;
        step_n++;
    endtask

    task automatic kw_track(input logic [7:0] c);
        if (kw_alive) begin
            if (kw_prog < 6 && kw_word[kw_prog] == c) kw_prog++;
            else kw_alive = 1'b0;
        end
    endtask

    task automatic flush_pending();
        case (lx_mode)
            M_IDENT: emit_tok((kw_alive && kw_prog == 6) ? K_RETURN : K_IDENT,
                              tok_start, tok_len, 0);
            M_NUM:   emit_tok(K_NUMBER, tok_start, tok_len, num_val);
            M_EQ:    emit_tok(K_ASSIGN, tok_start, 1, 0);
            M_BANG: begin
                emit_tok(K_ERROR, tok_start, 1, 0);
                lx_halted = 1'b1;
            end
            default: ;
        endcase
        lx_mode = M_IDLE;
    endtask

    task automatic lex_byte(input logic [7:0] c);
        longint unsigned d;
        logic [4:0]      k;
        d = c - "0";
        k = op_kind(c);
        if (lx_mode == M_IDENT && (is_letter(c) || is_digit(c))) begin
            kw_track(c);
            if (tok_len < 65535) tok_len++;
        end else if (lx_mode == M_NUM && is_digit(c)) begin
            if (num_val > (VAL_MAX - d) / 10) num_val = VAL_MAX;
            else num_val = num_val * 10 + d;
            if (tok_len < 65535) tok_len++;
        end else if (lx_mode == M_EQ && c == "=") begin
            lx_mode = M_IDLE;
            emit_tok(K_EQ, tok_start, 2, 0);
        end else if (lx_mode == M_BANG) begin
            lx_mode = M_IDLE;
            if (c == "=") begin
                emit_tok(K_NEQ, tok_start, 2, 0);
            end else begin
                lx_halted = 1'b1;
                emit_tok(K_ERROR, tok_start, 1, 0);
            end
        end else begin
            if (lx_mode != M_IDLE) flush_pending();
            if (!is_blank(c)) begin
                tok_start = lx_pos;
                tok_len   = 1;
                num_val   = 0;
                if (is_letter(c)) begin
                    lx_mode  = M_IDENT;
                    kw_alive = 1'b1;
                    kw_prog  = 0;
                    kw_track(c);
                end else if (c == "=") begin
                    lx_mode = M_EQ;
                end else if (c == "!") begin
                    lx_mode = M_BANG;
                end else if (k != K_ERROR) begin
                    emit_tok(k, lx_pos, 1, 0);
                end else if (is_digit(c)) begin
                    lx_mode = M_NUM;
                    num_val = d;
                end else begin
                    lx_halted = 1'b1;
                    emit_tok(K_ERROR, lx_pos, 1, 0);
                end
            end
        end
    endtask

    task automatic lex_step(input logic [7:0] c, input logic e);
        t_tok t;
        bit   was_bang;
        step_n = 0;
        if (e) begin
            if (!lx_halted) flush_pending();
            emit_tok(K_END, lx_pos, 0, 0);
            lex_reset();
            lexed_cnt++;
            texts_done++;
        end else if (!lx_halted) begin
            lexed_cnt++;
            if (lx_pos >= TEXT_LEN) begin
                was_bang = (lx_mode == M_BANG);
                flush_pending();
                if (!was_bang) emit_tok(K_ERROR, lx_pos, 0, 0);
                lx_halted = 1'b1;
                lx_mode   = M_IDLE;
            end else begin
                lex_byte(c);
                lx_pos++;
            end
        end
        for (int i = 0; i < step_n; i++) begin
            t = step_buf[i];
            t.end_of_run = (i == step_n - 1);
            tok_expect_q.push_back(t);
        end
    endtask

    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= 20) $display("ERROR %0t ns: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : check_tokens
        t_tok got;
        t_tok want;
        if (i_rst_n) begin
            if (src.valid && src.ready) lex_step(src.ch, src.is_end);
            if (res.valid && res.ready) begin
                got.kind       = res.kind;
                got.start_res  = res.start_res;
                got.length     = res.length;
                got.value      = res.value;
                got.end_of_run = res.end_of_run;
                tokens_checked++;
                if (tok_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected token kind %0d start %0d",
                                              got.kind, got.start_res));
                end else begin
                    want = tok_expect_q.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "token got k%0d s%0d l%0d v%0d e%0b exp k%0d s%0d l%0d v%0d e%0b",
                            got.kind, got.start_res, got.length, got.value, got.end_of_run,
                            want.kind, want.start_res, want.length, want.value,
                            want.end_of_run));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            res.ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            res.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_item(input logic [7:0] c, input logic e);
        while ($urandom_range(99) < src_idle_pct) begin
            src.valid <= 1'b0;
            @(posedge i_clk);
        end
        src.valid  <= 1'b1;
        src.ch     <= c;
        src.is_end <= e;
        do @(posedge i_clk); while (!src.ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic test_directed_tokens();
        send_text("return=9999999999!=_9==");
        send_end();
        send_text("+-*/%(),;\t=");
        send_end();
    endtask

    task automatic test_errors_and_halt();
        send_text("!x");
        send_end();
        send_item(8'hFF, 1'b0);
        send_item("a", 1'b0);
        send_end();
        send_item(8'h00, 1'b0);
        send_end();
    endtask

    task automatic test_backpressure();
        rx_hold = 80;
        repeat (20) send_text("=+");
        send_end();
    endtask

    task automatic send_random_text();
        int n_pieces;
        int sel;
        int len;
        n_pieces = $urandom_range(1, 12);
        repeat (n_pieces) begin
            sel = $urandom_range(99);
            if (sel < 28) begin
                case ($urandom_range(5))
                    0: send_text("return");
                    1: send_text("retur");
                    2: send_text("returnx");
                    default: begin
                        send_item(rand_letter(), 1'b0);
                        len = $urandom_range(0, 7);
                        repeat (len) send_item(rand_ident_char(), 1'b0);
                    end
                endcase
            end else if (sel < 48) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
                repeat (len) send_item(8'("0" + $urandom_range(9)), 1'b0);
            end else if (sel < 72) begin
                send_item(op_chars[$urandom_range(9)], 1'b0);
            end else if (sel < 80) begin
                send_text($urandom_range(1) ? "==" : "!=");
            end else if (sel < 92) begin
                send_item(rand_blank(), 1'b0);
            end else begin
                send_item($urandom_range(1) ? 8'h21 : 8'($urandom_range(255)), 1'b0);
            end
        end
        send_end();
    endtask

    task automatic test_random_texts(input int n_items);
        int first;
        first = lexed_cnt;
        while (lexed_cnt - first < n_items) send_random_text();
    endtask

    initial begin
        src.valid  = 1'b0;
        src.ch     = 8'h00;
        src.is_end = 1'b0;
        lex_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 12;
        sink_idle_pct = 70;
        test_directed_tokens();
        test_errors_and_halt();
        test_random_texts(100);

        src_idle_pct  = 70;
        sink_idle_pct = 12;
        test_random_texts(100);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_texts(110);
        test_backpressure();

        src.valid <= 1'b0;
        while (tok_expect_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Lexed %0d bytes and end items over %0d texts, checked %0d tokens.",
                 lexed_cnt, texts_done, tokens_checked);
        $display("Run hit every token kind, saturation, errors, halts and output stalls.");
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
